FILE: hw/rtl/epc_pkg.sv
// Package for the energy polynomial calibration block.
// Holds widths, item classes, register indexes and the item types shared by all modules.
// No dependencies.
package epc_pkg;

  localparam int ChargeW          = 24;
  localparam int DitherW          = 16;
  localparam int XW               = ChargeW + DitherW;
  localparam int AccW             = 48;
  localparam int CoefW            = 32;
  localparam int CountW           = 3;
  localparam int IntegW           = 16;
  localparam int DivW             = IntegW - 2;
  localparam int NumCoeffRegs     = 4;
  localparam int MaxCoeffsDefault = 4;
  localparam int FifoDepth        = 2;
  localparam int CfgIndexW        = 3;
  localparam int CfgDataW         = 32;
  localparam int FracBits         = 16;

  localparam logic [DivW-1:0] DefaultDivisor = DivW'(125);
  localparam logic [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  typedef enum logic [1:0] {
    CLS_PASS,
    CLS_FAULT,
    CLS_CALC
  } cls_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_COEFF_COUNT = 3'd0,
    REG_INTEG       = 3'd1,
    REG_C0          = 3'd2,
    REG_C1          = 3'd3,
    REG_C2          = 3'd4,
    REG_C3          = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    cls_e            cls;
    logic            u_neg;
    logic [XW-1:0]   u_mag;
  } q_item_t;

  typedef struct packed {
    logic            vld;
    cls_e            cls;
    logic            u_neg;
    logic [XW-1:0]   u_mag;
    logic [AccW-1:0] acc;
    logic            sat;
  } item_t;

endpackage

FILE: hw/rtl/epc_front.sv
// Front end: accepts words, classifies them and divides the dithered charge.
// The divider is a restoring pipeline with one quotient bit per stage.
// Depends on epc_pkg.
module epc_front import epc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [ChargeW-1:0]   raw_charge_i,
  input  logic        [DitherW-1:0]   dither_i,
  input  logic                        n_zero_i,
  input  logic        [IntegW-1:0]    integration_length_i,
  input  logic                        full_i,
  output logic                        busy_o,
  output logic                        push_o,
  output q_item_t                     item_o
);

  logic            en;
  cls_e            cls_d;
  logic [DivW-1:0] div;

  logic            a_vld_q;
  logic [XW-1:0]   a_x_q;
  cls_e            a_cls_q;

  logic            dv_vld_q [XW+1];
  logic [XW-1:0]   dv_dq_q  [XW+1];
  logic [DivW-1:0] dv_rem_q [XW+1];
  logic            dv_neg_q [XW+1];
  cls_e            dv_cls_q [XW+1];

  assign en     = !full_i;
  assign busy_o = full_i;

  always_comb begin
    cls_d = CLS_CALC;
    div   = integration_length_i[IntegW-1:2];
    if (n_zero_i) begin
      cls_d = CLS_PASS;
      div   = DivW'(1);
    end else if (integration_length_i == '0) begin
      div = DefaultDivisor;
    end else if (integration_length_i[IntegW-1:2] == '0) begin
      cls_d = CLS_FAULT;
      div   = DivW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      dv_vld_q[0] <= 1'b0;
    end else if (en) begin
      a_vld_q     <= start_i;
      dv_vld_q[0] <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_x_q       <= {raw_charge_i, dither_i};
      a_cls_q     <= cls_d;
      dv_neg_q[0] <= a_x_q[XW-1];
      dv_dq_q[0]  <= a_x_q[XW-1] ? -a_x_q : a_x_q;
      dv_rem_q[0] <= '0;
      dv_cls_q[0] <= a_cls_q;
    end
  end

  for (genvar k = 0; k < XW; k++) begin : g_div
    logic [DivW:0] t;
    logic          ge;
    assign t  = {dv_rem_q[k], dv_dq_q[k][XW-1]};
    assign ge = t >= {1'b0, div};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[k+1] <= ge ? DivW'(t - {1'b0, div}) : t[DivW-1:0];
        dv_dq_q[k+1]  <= {dv_dq_q[k][XW-2:0], ge};
        dv_neg_q[k+1] <= dv_neg_q[k];
        dv_cls_q[k+1] <= dv_cls_q[k];
      end
    end
  end

  assign push_o       = dv_vld_q[XW] && en;
  assign item_o.cls   = dv_cls_q[XW];
  assign item_o.u_neg = dv_neg_q[XW] && (dv_dq_q[XW] != '0);
  assign item_o.u_mag = dv_dq_q[XW];

endmodule

FILE: hw/rtl/epc_fifo.sv
// Short queue between the divider front end and the polynomial back end.
// Register based, first in first out.
// Depends on epc_pkg.
module epc_fifo import epc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t data_i,
  input  logic    pop_i,
  output q_item_t data_o,
  output logic    full_o,
  output logic    empty_o
);

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);

  q_item_t         mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(FifoDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/epc_step.sv
// One Horner step: acc = floor(acc * u / 2^16) + c, clamped to 48 bits.
// Five register stages: magnitude, partial products, sum, scale, add.
// Depends on epc_pkg.
module epc_step import epc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  item_t                   item_i,
  input  logic                    act_i,
  input  logic signed [CoefW-1:0] coeff_i,
  output item_t                   item_o
);

  localparam int PW = AccW + XW;

  item_t           it0_q, it1_q, it2_q, it3_q, it4_q;
  logic            act0_q, act1_q, act2_q, act3_q;
  logic            neg0_q, neg1_q, neg2_q;
  logic [AccW-1:0] ua0_q;
  logic [63:0]     pll_q;
  logic [39:0]     plh_q;
  logic [47:0]     phl_q;
  logic [23:0]     phh_q;
  logic [PW-1:0]   p2_q;
  logic [AccW-1:0] m3_q;
  logic            s3_q;

  logic [63:0]     pll_d;
  logic [39:0]     plh_d;
  logic [47:0]     phl_d;
  logic [23:0]     phh_d;
  logic [48:0]     mid;
  logic [PW-1:0]   p_d;
  logic [PW-FracBits-1:0] q;
  logic [PW-FracBits:0]   mag;
  logic [AccW-1:0] m_d;
  logic            s_d;
  logic [AccW:0]   sum;
  logic [AccW-1:0] acc_d;
  logic            sat_d;
  item_t           it4_d;

  assign pll_d = ua0_q[31:0] * it0_q.u_mag[31:0];
  assign plh_d = ua0_q[31:0] * it0_q.u_mag[XW-1:32];
  assign phl_d = ua0_q[AccW-1:32] * it0_q.u_mag[31:0];
  assign phh_d = ua0_q[AccW-1:32] * it0_q.u_mag[XW-1:32];

  assign mid = 49'(plh_q) + 49'(phl_q);
  assign p_d = {phh_q, pll_q} + (PW'(mid) << 32);

  assign q   = p2_q[PW-1:FracBits];
  assign mag = {1'b0, q} + (PW-FracBits+1)'(p2_q[FracBits-1:0] != '0);

  always_comb begin
    s_d = 1'b0;
    m_d = '0;
    if (neg2_q) begin
      if (mag > (PW-FracBits+1)'(AccMin)) begin
        s_d = 1'b1;
        m_d = AccMin;
      end else begin
        m_d = -mag[AccW-1:0];
      end
    end else begin
      if (q > (PW-FracBits)'(AccMax)) begin
        s_d = 1'b1;
        m_d = AccMax;
      end else begin
        m_d = q[AccW-1:0];
      end
    end
  end

  assign sum = {m3_q[AccW-1], m3_q} + {{(AccW+1-CoefW){coeff_i[CoefW-1]}}, coeff_i};

  always_comb begin
    acc_d = sum[AccW-1:0];
    sat_d = s3_q;
    if (sum[AccW] != sum[AccW-1]) begin
      acc_d = sum[AccW] ? AccMin : AccMax;
      sat_d = 1'b1;
    end
  end

  always_comb begin
    it4_d = it3_q;
    if (act3_q) begin
      it4_d.acc = acc_d;
      it4_d.sat = it3_q.sat | sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it0_q  <= '0;
      it1_q  <= '0;
      it2_q  <= '0;
      it3_q  <= '0;
      it4_q  <= '0;
      act0_q <= 1'b0;
      act1_q <= 1'b0;
      act2_q <= 1'b0;
      act3_q <= 1'b0;
    end else begin
      it0_q  <= item_i;
      it1_q  <= it0_q;
      it2_q  <= it1_q;
      it3_q  <= it2_q;
      act0_q <= act_i;
      act1_q <= act0_q;
      act2_q <= act1_q;
      act3_q <= act2_q;
      it4_q  <= it4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg0_q <= item_i.acc[AccW-1] ^ item_i.u_neg;
    ua0_q  <= item_i.acc[AccW-1] ? -item_i.acc : item_i.acc;
    neg1_q <= neg0_q;
    pll_q  <= pll_d;
    plh_q  <= plh_d;
    phl_q  <= phl_d;
    phh_q  <= phh_d;
    neg2_q <= neg1_q;
    p2_q   <= p_d;
    m3_q   <= m_d;
    s3_q   <= s_d;
  end

  assign item_o = it4_q;

endmodule

FILE: hw/rtl/energy_polynomial_calibration.sv
// Top level of the energy polynomial calibration block.
// Holds the configuration registers and connects epc_front, epc_fifo and epc_step.
// Depends on epc_pkg, epc_front, epc_fifo, epc_step.
//
// A word is taken at a rising edge with start_i high and busy_o low. It carries a
// signed raw charge and an unsigned Q0.16 dither. Every word gives exactly one
// result: done_o is high for one cycle with energy_o (signed Q32.16), saturated_o
// and divide_fault_o. The receiver cannot stall, so results are never held back.
// The front end divides over a pipeline of 40 one-bit stages; the back end runs
// MAX_COEFFS-1 Horner steps of five stages each, with the multiply split into
// partial products at bit 32. One word is taken every cycle while busy_o is low.
// busy_o rises only if the queue between the front and back ends fills.
// Configuration words are written through cfg_valid_i / cfg_ready_o with a
// register index and data; ready is always high. Writes must go in only while no
// word is in flight; the block itself does not enforce this. Reset clears the
// configuration registers and the valid bits, which empties the pipeline.
module energy_polynomial_calibration import epc_pkg::*; #(
  parameter int MAX_COEFFS = MaxCoeffsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [ChargeW-1:0]   raw_charge_i,
  input  logic        [DitherW-1:0]   dither_i,
  output logic                        done_o,
  output logic signed [AccW-1:0]      energy_o,
  output logic                        saturated_o,
  output logic                        divide_fault_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic        [CfgIndexW-1:0] cfg_index_i,
  input  logic        [CfgDataW-1:0]  cfg_data_i
);

  logic [CountW-1:0]       count_q;
  logic [IntegW-1:0]       integ_q;
  logic signed [CoefW-1:0] coeff_q [NumCoeffRegs];

  logic [CountW-1:0]       n;
  logic [CountW-1:0]       nm1;
  logic signed [CoefW-1:0] c_top;

  logic    push, full, empty;
  q_item_t fq_in, fq_out;
  item_t   stg [MAX_COEFFS];

  logic            done_q, sat_q, fault_q;
  logic [AccW-1:0] energy_q;
  logic [AccW-1:0] energy_d;
  logic            sat_d, fault_d;
  item_t           last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      integ_q <= '0;
      for (int i = 0; i < NumCoeffRegs; i++) begin
        coeff_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i) inside
        REG_COEFF_COUNT: count_q <= cfg_data_i[CountW-1:0];
        REG_INTEG:       integ_q <= cfg_data_i[IntegW-1:0];
        REG_C0, REG_C1, REG_C2, REG_C3: begin
          coeff_q[2'(cfg_index_i - REG_C0)] <= cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  assign n   = (int'(count_q) > MAX_COEFFS) ? CountW'(MAX_COEFFS) : count_q;
  assign nm1 = n - CountW'(1);
  assign c_top = (int'(nm1) < NumCoeffRegs) ? coeff_q[2'(nm1)] : '0;

  epc_front u_front (
    .clk_i,
    .rst_ni,
    .start_i,
    .raw_charge_i,
    .dither_i,
    .n_zero_i             (n == '0),
    .integration_length_i (integ_q),
    .full_i               (full),
    .busy_o,
    .push_o               (push),
    .item_o               (fq_in)
  );

  epc_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (fq_in),
    .pop_i   (!empty),
    .data_o  (fq_out),
    .full_o  (full),
    .empty_o (empty)
  );

  assign stg[0].vld   = !empty;
  assign stg[0].cls   = fq_out.cls;
  assign stg[0].u_neg = fq_out.u_neg;
  assign stg[0].u_mag = fq_out.u_mag;
  assign stg[0].acc   = {{(AccW-CoefW){c_top[CoefW-1]}}, c_top};
  assign stg[0].sat   = 1'b0;

  for (genvar s = 1; s < MAX_COEFFS; s++) begin : g_step
    logic                    act;
    logic signed [CoefW-1:0] c;
    assign act = stg[s-1].vld && (stg[s-1].cls == CLS_CALC) && (int'(n) > MAX_COEFFS - s);
    if (MAX_COEFFS - s - 1 < NumCoeffRegs) begin : g_coef
      assign c = coeff_q[MAX_COEFFS-s-1];
    end else begin : g_zero
      assign c = '0;
    end
    epc_step u_step (
      .clk_i,
      .rst_ni,
      .item_i  (stg[s-1]),
      .act_i   (act),
      .coeff_i (c),
      .item_o  (stg[s])
    );
  end

  assign last = stg[MAX_COEFFS-1];

  always_comb begin
    energy_d = last.acc;
    sat_d    = last.sat;
    fault_d  = 1'b0;
    case (last.cls)
      CLS_PASS: begin
        energy_d = last.u_neg ? -AccW'(last.u_mag) : AccW'(last.u_mag);
        sat_d    = 1'b0;
      end
      CLS_FAULT: begin
        energy_d = '0;
        sat_d    = 1'b0;
        fault_d  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    energy_q <= energy_d;
    sat_q    <= sat_d;
    fault_q  <= fault_d;
  end

  assign done_o         = done_q;
  assign energy_o       = energy_q;
  assign saturated_o    = sat_q;
  assign divide_fault_o = fault_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("Queue between front and back end filled up.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && divide_fault_o |-> energy_o == '0 && !saturated_o)
    else $error("Divide fault result is not a clean zero.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(n == '0, 1) && $stable(count_q) |-> !saturated_o && !divide_fault_o)
    else $error("Passthrough result carries a flag.");

endmodule

FILE: tb/sv/energy_polynomial_calibration_checker.sv
// Checker for the energy polynomial calibration block: watches the word and result
// ports, predicts each result from its own copy of the registers and compares.
// Depends on epc_pkg.
`timescale 1ns / 1ps
module energy_polynomial_calibration_checker import epc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic signed [ChargeW-1:0]   raw_charge_i,
  input  logic        [DitherW-1:0]   dither_i,
  input  logic                        done_i,
  input  logic signed [AccW-1:0]      energy_i,
  input  logic                        saturated_i,
  input  logic                        divide_fault_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic        [CfgIndexW-1:0] cfg_index_i,
  input  logic        [CfgDataW-1:0]  cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);

  typedef struct packed {
    logic signed [AccW-1:0] energy;
    logic                   sat;
    logic                   fault;
  } energy_t;

  localparam longint EMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint EMin = -64'sh0000_8000_0000_0000;

  logic [CountW-1:0]        count_q;
  logic [IntegW-1:0]        integ_q;
  logic signed [CoefW-1:0]  coef_q [NumCoeffRegs];
  energy_t                  energy_queue [$];

  assign pending_o = energy_queue.size();

  function automatic longint clip48(input logic signed [127:0] v, inout logic sat);
    if (v > EMax) begin
      sat = 1'b1;
      return EMax;
    end
    if (v < EMin) begin
      sat = 1'b1;
      return EMin;
    end
    return longint'(v);
  endfunction

  function automatic energy_t calibrate(input logic signed [ChargeW-1:0] charge,
                                        input logic [DitherW-1:0] dith);
    energy_t r;
    longint x, u, acc, d;
    logic signed [127:0] prod;
    int n;
    r = '0;
    x = longint'(charge) * 65536 + longint'(dith);
    n = (count_q > 3'(MaxCoeffsDefault)) ? MaxCoeffsDefault : int'(count_q);
    if (n == 0) begin
      r.energy = AccW'(x);
      return r;
    end
    d = (integ_q == 0) ? 125 : longint'(integ_q / 4);
    if (d == 0) begin
      r.fault = 1'b1;
      return r;
    end
    u = (x < 0) ? -((-x) / d) : x / d;
    acc = coef_q[n-1];
    for (int i = n - 1; i > 0; i--) begin
      prod = 128'(acc) * 128'(u);
      prod = prod >>> 16;
      acc = clip48(prod, r.sat);
      acc = clip48(128'(acc) + 128'(longint'(coef_q[i-1])), r.sat);
    end
    r.energy = AccW'(acc);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    checked_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    energy_t e;
    if (!rst_ni) begin
      count_q <= '0;
      integ_q <= '0;
      foreach (coef_q[i]) coef_q[i] <= '0;
      energy_queue.delete();
    end else begin
      if (done_i) begin
        if (energy_queue.size() == 0) begin
          report_mismatch("unexpected word", energy_i, 0);
        end else begin
          e = energy_queue.pop_front();
          checked_o++;
          if (energy_i !== e.energy) report_mismatch("energy", energy_i, e.energy);
          if (saturated_i !== e.sat) report_mismatch("saturated", saturated_i, e.sat);
          if (divide_fault_i !== e.fault) report_mismatch("divide_fault", divide_fault_i, e.fault);
        end
      end
      if (start_i && !busy_i) energy_queue.push_back(calibrate(raw_charge_i, dither_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_COEFF_COUNT: count_q <= cfg_data_i[CountW-1:0];
          REG_INTEG:       integ_q <= cfg_data_i[IntegW-1:0];
          REG_C0:          coef_q[0] <= cfg_data_i;
          REG_C1:          coef_q[1] <= cfg_data_i;
          REG_C2:          coef_q[2] <= cfg_data_i;
          REG_C3:          coef_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: tb/sv/energy_polynomial_calibration_tb.sv
// Testbench top for the energy polynomial calibration block: drives configuration
// phases and charge words, some with random gaps, and gives the verdict from the checker.
// Depends on epc_pkg, energy_polynomial_calibration, energy_polynomial_calibration_checker.
`timescale 1ns / 1ps
module energy_polynomial_calibration_tb import epc_pkg::*;;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic signed [ChargeW-1:0]   raw_charge_i = '0;
  logic        [DitherW-1:0]   dither_i = '0;
  logic                        done_o;
  logic signed [AccW-1:0]      energy_o;
  logic                        saturated_o;
  logic                        divide_fault_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic        [CfgIndexW-1:0] cfg_index_i = '0;
  logic        [CfgDataW-1:0]  cfg_data_i = '0;
  int                          fail_count;
  int                          pending;
  int                          checked;
  int                          word_total = 0;

  always #5 clk_i = ~clk_i;

  energy_polynomial_calibration DUT (.*);

  energy_polynomial_calibration_checker u_checker (
    .busy_i(busy_o), .done_i(done_o), .energy_i(energy_o), .saturated_i(saturated_o),
    .divide_fault_i(divide_fault_o), .cfg_ready_i(cfg_ready_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked), .*);

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic send_word(input logic [ChargeW-1:0] charge, input logic [DitherW-1:0] dith,
                           input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    raw_charge_i <= charge;
    dither_i     <= dith;
    do @(posedge clk_i); while (busy_o);
    word_total++;
  endtask

  function automatic logic [31:0] rand_coef(input int kind);
    case (kind)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 262143)) - 131072);
      default: return $urandom();
    endcase
  endfunction

  task automatic setup(input logic [2:0] n, input logic [15:0] integ, input int kind);
    write_reg(REG_COEFF_COUNT, 32'(n));
    write_reg(REG_INTEG, 32'(integ));
    write_reg(REG_C0, rand_coef(kind));
    write_reg(REG_C1, rand_coef(kind));
    write_reg(REG_C2, rand_coef(kind));
    write_reg(REG_C3, rand_coef(kind));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic directed_words();
    send_word(24'h7FFFFF, 16'hFFFF, 1'b0);
    send_word(24'h800000, 16'h0000, 1'b0);
    send_word(24'h000000, 16'h0000, 1'b0);
    send_word(24'hFFFFFF, 16'h0001, 1'b0);
    send_word(24'h000001, 16'h8000, 1'b0);
  endtask

  initial begin
    int phase;
    bit bursty;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_words();
    start_i <= 1'b0;
    drain();
    setup(3'd4, 16'd0, 0);
    directed_words();
    start_i <= 1'b0;
    drain();
    setup(3'd4, 16'd2, 1);
    directed_words();
    start_i <= 1'b0;
    drain();
    setup(3'd7, 16'hFFFF, 1);
    directed_words();
    start_i <= 1'b0;
    drain();
    setup(3'd1, 16'd4, 3);
    directed_words();
    start_i <= 1'b0;
    drain();
    for (phase = 0; phase < 15; phase++) begin
      setup(3'($urandom_range(0, 7)),
            ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 8)) : 16'($urandom()),
            $urandom_range(0, 3));
      bursty = $urandom_range(0, 1);
      repeat (30) send_word(24'($urandom()), 16'($urandom()), bursty);
      start_i <= 1'b0;
      drain();
    end
    $display("ran %0d words over 21 register settings, %0d results checked",
             word_total, checked);
    if (fail_count == 0) begin
      $display("energy_polynomial_calibration_tb passed");
    end else begin
      $display("energy_polynomial_calibration_tb failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("energy_polynomial_calibration_tb failed");
    $finish;
  end

endmodule
